[design/hncp_pkg.sv]
// shared types, codes and the status rule for the tlv stream checker
`default_nettype none

package hncp_pkg;

  // parse phase of the stream
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_PAD,
    PH_DRAIN
  } hncp_phase_t;

  // per-tlv status code
  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_FATAL,
    ST_TRUNC
  } hncp_status_t;

  // tlv types with a minimum body length
  localparam logic [15:0] TYPE_TWO   = 16'd2;
  localparam logic [15:0] TYPE_THREE = 16'd3;
  localparam logic [15:0] TYPE_FOUR  = 16'd4;
  localparam logic [15:0] TYPE_FIVE  = 16'd5;

  // minimum body lengths
  localparam logic [15:0] MIN_LEN_TWO   = 16'd4;
  localparam logic [15:0] MIN_LEN_THREE = 16'd8;
  localparam logic [15:0] MIN_LEN_FOUR  = 16'd8;
  localparam logic [15:0] MIN_LEN_FIVE  = 16'd20;

  // one result of the parser
  typedef struct packed {
    logic [15:0]  tlv_type;
    logic [15:0]  body_length;
    hncp_status_t tlv_status;
    logic         tlv_report;
    logic         packet_end;
    logic         packet_ok;
  } hncp_result_t;

  // parser state seen by the top level
  typedef struct packed {
    hncp_phase_t phase;
    logic [1:0]  header_count;
    logic        packet_failed;
  } hncp_state_t;

  // status of a complete tlv from its type and declared length
  function automatic hncp_status_t hncp_judge(input logic [15:0] t, input logic [15:0] len);
    hncp_status_t st;
    st = ST_OK;
    priority if (t == TYPE_TWO && len < MIN_LEN_TWO) st = ST_FATAL;
    else if (t == TYPE_FOUR && len < MIN_LEN_FOUR) st = ST_FATAL;
    else if (t == TYPE_FIVE && len < MIN_LEN_FIVE) st = ST_FATAL;
    else if (t == TYPE_THREE && len < MIN_LEN_THREE) st = ST_SHORT;
    else st = ST_OK;
    return st;
  endfunction

endpackage

`default_nettype wire

[design/hncp_stream_if.sv]
// valid/ready channels for packet bytes and tlv results
`default_nettype none

interface hncp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hncp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tlv_type;
  logic [15:0] body_length;
  logic [1:0]  tlv_status;
  logic        tlv_report;
  logic        packet_end;
  logic        packet_ok;

  modport source (
    output valid, output tlv_type, output body_length, output tlv_status,
    output tlv_report, output packet_end, output packet_ok, input ready
  );
  modport sink (
    input valid, input tlv_type, input body_length, input tlv_status,
    input tlv_report, input packet_end, input packet_ok, output ready
  );
endinterface

`default_nettype wire

[design/hncp_tlv_core.sv]
// tlv parse state and per-byte result logic
`default_nettype none

module hncp_tlv_core
  import hncp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   data_byte,
  input  wire logic         last_byte,
  output hncp_result_t      result,
  output logic              has_result,
  output hncp_state_t       state
);

  hncp_phase_t phase_r, phase_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] body_left_r, body_left_nxt;
  logic [1:0]  pad_left_r, pad_left_nxt;
  logic        failed_r, failed_nxt;

  logic [15:0]  cur_type;
  logic [15:0]  cur_len;
  logic [15:0]  body_dec;
  logic [1:0]   pad_dec;
  logic [1:0]   pad_fill;
  logic         report;
  logic         failing;
  hncp_status_t status;
  hncp_status_t judged;

  // header bytes merged into type and length as they arrive
  always_comb begin
    cur_type = type_r;
    cur_len  = len_r;
    if (phase_r == PH_HEADER) begin
      unique case (header_count_r)
        2'd0: begin
          cur_type = {data_byte, 8'h00};
          cur_len  = 16'h0000;
        end
        2'd1: cur_type = {type_r[15:8], data_byte};
        2'd2: cur_len  = {data_byte, 8'h00};
        2'd3: cur_len  = {len_r[15:8], data_byte};
        default: cur_len = len_r;
      endcase
    end
  end

  assign body_dec = body_left_r - 16'd1;
  assign pad_dec  = pad_left_r - 2'd1;
  assign pad_fill = 2'd0 - cur_len[1:0];
  assign judged   = hncp_judge(cur_type, cur_len);

  // report and status of this byte
  always_comb begin
    report = 1'b0;
    status = ST_OK;
    unique case (phase_r)
      PH_HEADER: begin
        if (header_count_r != 2'd3) begin
          report = last_byte;
          status = ST_TRUNC;
        end else if (cur_len == 16'h0000) begin
          report = 1'b1;
          status = judged;
        end else begin
          report = last_byte;
          status = ST_TRUNC;
        end
      end
      PH_BODY: begin
        if (body_dec == 16'h0000) begin
          report = 1'b1;
          status = judged;
        end else begin
          report = last_byte;
          status = ST_TRUNC;
        end
      end
      PH_PAD,
      PH_DRAIN: begin
        report = 1'b0;
        status = ST_OK;
      end
      default: report = 1'b0;
    endcase
  end

  assign failing = report && (status == ST_FATAL || status == ST_TRUNC);

  // next parse state
  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    type_nxt         = type_r;
    len_nxt          = len_r;
    body_left_nxt    = body_left_r;
    pad_left_nxt     = pad_left_r;
    failed_nxt       = failed_r;
    if (last_byte) begin
      // packet end returns everything to reset
      phase_nxt        = PH_HEADER;
      header_count_nxt = 2'd0;
      type_nxt         = 16'h0000;
      len_nxt          = 16'h0000;
      body_left_nxt    = 16'h0000;
      pad_left_nxt     = 2'd0;
      failed_nxt       = 1'b0;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          type_nxt         = cur_type;
          len_nxt          = cur_len;
          header_count_nxt = header_count_r + 2'd1;
          if (header_count_r == 2'd3 && cur_len != 16'h0000) begin
            body_left_nxt = cur_len;
            phase_nxt     = PH_BODY;
          end
        end
        PH_BODY: body_left_nxt = body_dec;
        PH_PAD: begin
          pad_left_nxt = pad_dec;
          if (pad_dec == 2'd0) phase_nxt = PH_HEADER;
        end
        PH_DRAIN: phase_nxt = PH_DRAIN;
        default: phase_nxt = PH_DRAIN;
      endcase
      // finished tlv: drain on failure, else pad to alignment
      if (report) begin
        if (failing) begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_DRAIN;
        end else begin
          pad_left_nxt = pad_fill;
          phase_nxt    = (pad_fill != 2'd0) ? PH_PAD : PH_HEADER;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= 2'd0;
      type_r         <= 16'h0000;
      len_r          <= 16'h0000;
      body_left_r    <= 16'h0000;
      pad_left_r     <= 2'd0;
      failed_r       <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      type_r         <= type_nxt;
      len_r          <= len_nxt;
      body_left_r    <= body_left_nxt;
      pad_left_r     <= pad_left_nxt;
      failed_r       <= failed_nxt;
    end
  end

  // result fields, zeroed where they carry no meaning
  always_comb begin
    has_result         = report || last_byte;
    result.tlv_type    = report ? cur_type : 16'h0000;
    result.body_length = report ? cur_len : 16'h0000;
    result.tlv_status  = report ? status : ST_OK;
    result.tlv_report  = report;
    result.packet_end  = last_byte;
    result.packet_ok   = last_byte && !(failed_r || failing);
  end

  assign state.phase         = phase_r;
  assign state.header_count  = header_count_r;
  assign state.packet_failed = failed_r;

endmodule

`default_nettype wire

[design/hncp_tlv_stream_checker.sv]
// a byte's result is held in the input register and then in the output register
// throughput: one byte per cycle; stalls only while the output register is held
// the input register and output register are the two pipeline stages
// reset: synchronous active-low rst_n clears parse state and both stage valids
// after reset the block is ready to take a byte
`default_nettype none

module hncp_tlv_stream_checker
  import hncp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  hncp_in_if.sink     in_stream,
  hncp_out_if.source  out_stream
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         out_valid_r;
  hncp_result_t out_r;
  logic         out_free;
  logic         s1_adv;
  logic         core_has;
  hncp_result_t core_res;
  hncp_state_t  core_state;

  // stage handshake
  assign out_free        = !out_valid_r || out_stream.ready;
  assign s1_adv          = s1_valid_r && out_free;
  assign in_stream.ready = !s1_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      s1_byte_r <= in_stream.data_byte;
      s1_last_r <= in_stream.last_byte;
    end
  end

  hncp_tlv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .result     (core_res),
    .has_result (core_has),
    .state      (core_state)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= core_has;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && core_has) begin
      out_r <= core_res;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.tlv_type    = out_r.tlv_type;
  assign out_stream.body_length = out_r.body_length;
  assign out_stream.tlv_status  = out_r.tlv_status;
  assign out_stream.tlv_report  = out_r.tlv_report;
  assign out_stream.packet_end  = out_r.packet_end;
  assign out_stream.packet_ok   = out_r.packet_ok;

  // packet end always brings the parser back to a clean header phase
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> core_state.phase == PH_HEADER &&
      core_state.header_count == 2'd0 && !core_state.packet_failed)
    else $error("parser not reset after packet end");

  // a fatal or truncated tlv inside the packet moves to drain
  a_fail_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_last_r && core_res.tlv_report &&
      (core_res.tlv_status == ST_FATAL || core_res.tlv_status == ST_TRUNC)
    |=> core_state.phase == PH_DRAIN && core_state.packet_failed)
    else $error("failure did not enter drain");

  // nothing but the packet end leaves the drain phase as a result
  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && core_state.phase == PH_DRAIN |-> core_has == s1_last_r &&
      !core_res.tlv_report)
    else $error("result produced while draining");

  // packet_ok only rides on a packet end
  a_ok_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.packet_ok |-> out_r.packet_end)
    else $error("packet_ok without packet_end");

endmodule

`default_nettype wire
